[rtl/sphv_pkg.sv]
`default_nettype none
package sphv_pkg;

   // precision register and index widths
   localparam int PW            = 9;
   localparam int MAX_PRECISION = 256;
   localparam logic [PW-1:0] PRECISION_RESET = PW'(48);
   localparam logic [PW-1:0] PRECISION_MAX   = PW'(MAX_PRECISION);
   localparam logic [PW-1:0] PRECISION_MIN   = PW'(1);
   localparam int IDX_W         = 17;
   localparam int OUT_W         = 16;
   localparam int FRAC_BITS     = 14;

   // request and result codes
   localparam logic REQ_VERTEX  = 1'b0;
   localparam logic REQ_QUAD    = 1'b1;
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // phase divider
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = 8;
   localparam int DIV_LAT       = DIV_STAGES + 1;
   localparam int SEG_STEPS     = 32;
   localparam int RING_STEPS    = 31;
   localparam int TEX_STEPS     = 15;
   localparam int PHASE_W       = 32;

   // rotation unit, Q2.30
   localparam int CORDIC_W     = 32;
   localparam int CORDIC_ZW    = 33;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam logic signed [CORDIC_W-1:0]  CORDIC_GAIN    = 32'sd652032874;
   localparam logic signed [CORDIC_ZW-1:0] CORDIC_QUARTER = 33'sd1073741824;
   localparam logic signed [CORDIC_ZW-1:0] CORDIC_HALF    = 33'sd2147483648;
   localparam logic signed [CORDIC_ZW-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
      33'sd21354465, 33'sd10680862, 33'sd5340245, 33'sd2670163, 33'sd1335087,
      33'sd667544, 33'sd333772, 33'sd166886, 33'sd83443, 33'sd41722,
      33'sd20861, 33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
      33'sd652, 33'sd326, 33'sd163, 33'sd81, 33'sd41,
      33'sd20, 33'sd10, 33'sd5, 33'sd3, 33'sd1
   };

   // back pipeline: divider, rotation, prep, multiply, round
   localparam int PIPE_LAT  = DIV_LAT + CORDIC_LAT + 3;
   localparam int TEX_STAGE = DIV_LAT;

   localparam int QSEQ_W = 3;
   localparam logic [QSEQ_W-1:0] QUAD_LAST = 3'd5;

   typedef struct packed {
      logic            kind;
      logic            bad;
      logic            pole;
      logic            north;
      logic [PW-1:0]   ring;
      logic [PW-1:0]   segment;
      logic [IDX_W-1:0] base;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/uv_sphere_vertex_generator_core.sv]
`default_nettype none
// UV sphere generator. A vertex request returns one result per clock in steady
// state: the position (also the normal) in Q2.14, texture coordinates in Q1.15
// and the tangent. A quad request returns its six triangle corner indices one
// after another, the sixth marked last; an out-of-range request gives one result
// with bad_request set. Rate is one result per cycle while rsp_ready is high,
// set by the output register; a quad holds the pipeline tail until its sixth
// index is loaded. On its way to its first result a request passes the front
// register, the command queue, a 44-stage back pipeline (9 divider stages, 32
// rotation stages, prep, multiply, round) and the output register. The queue
// keeps taking requests while a result waits. Write precision only while idle.
module uv_sphere_vertex_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sphv_pkg::PW-1:0]             csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [sphv_pkg::PW-1:0]             req_ring,
   input  logic [sphv_pkg::PW-1:0]             req_segment,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [sphv_pkg::IDX_W-1:0]          rsp_vertex_index,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_x,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_y,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_z,
   output logic [sphv_pkg::OUT_W-1:0]          rsp_tex_u,
   output logic [sphv_pkg::OUT_W-1:0]          rsp_tex_v,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_tangent_x,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_tangent_z,
   output logic                                rsp_last,
   output logic                                rsp_bad_request
);

   logic [sphv_pkg::PW-1:0] precision_ff, precision_in;
   logic                    push, pop, q_full, q_empty;
   sphv_pkg::cmd_type       cmd, q_head;

   // store the precision already clamped to its working range
   always_comb begin
      precision_in = csr_wr_data;
      if (csr_wr_data == '0) begin
         precision_in = sphv_pkg::PRECISION_MIN;
      end else if (csr_wr_data > sphv_pkg::PRECISION_MAX) begin
         precision_in = sphv_pkg::PRECISION_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= sphv_pkg::PRECISION_RESET;
      end else if (csr_wr_en) begin
         precision_ff <= precision_in;
      end
   end

   sphv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .p_eff       (precision_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_ring    (req_ring),
      .req_segment (req_segment),
      .q_full      (q_full),
      .push        (push),
      .cmd         (cmd)
   );

   sphv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   sphv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .p_eff            (precision_ff),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (pop),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_tangent_x    (rsp_tangent_x),
      .rsp_tangent_z    (rsp_tangent_z),
      .rsp_last         (rsp_last),
      .rsp_bad_request  (rsp_bad_request)
   );

endmodule
`default_nettype wire

[rtl/sphv_front.sv]
`default_nettype none
module sphv_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sphv_pkg::PW-1:0]     p_eff,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [sphv_pkg::PW-1:0]     req_ring,
   input  logic [sphv_pkg::PW-1:0]     req_segment,
   input  logic                        q_full,
   output logic                        push,
   output sphv_pkg::cmd_type           cmd
);

   logic              cmd_valid_ff;
   logic              cmd_valid_in;
   sphv_pkg::cmd_type cmd_ff;
   sphv_pkg::cmd_type cmd_in;
   logic [sphv_pkg::PW:0] p1;
   logic [18:0]       prod;

   assign req_ready = !cmd_valid_ff || !q_full;
   assign push      = cmd_valid_ff && !q_full;
   assign cmd       = cmd_ff;

   assign p1   = {1'b0, p_eff} + 10'd1;
   assign prod = 19'(req_ring) * 19'(p1);

   always_comb begin
      cmd_in.kind    = req_type;
      if (req_type == sphv_pkg::REQ_QUAD) begin
         cmd_in.bad = (req_ring >= p_eff) || (req_segment >= p_eff);
      end else begin
         cmd_in.bad = (req_ring > p_eff) || (req_segment > p_eff);
      end
      cmd_in.pole    = (req_ring == '0) || (req_ring == p_eff);
      cmd_in.north   = (req_ring == p_eff);
      cmd_in.ring    = req_ring;
      cmd_in.segment = req_segment;
      cmd_in.base    = sphv_pkg::IDX_W'(prod + 19'(req_segment));
   end

   assign cmd_valid_in = req_ready ? req_valid : cmd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

[rtl/sphv_queue.sv]
`default_nettype none
module sphv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sphv_pkg::cmd_type push_data,
   input  logic              pop,
   output sphv_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);

   sphv_pkg::cmd_type              mem_ff [sphv_pkg::QUEUE_DEPTH];
   logic [sphv_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sphv_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sphv_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == sphv_pkg::QCNT_W'(sphv_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/sphv_div.sv]
`default_nettype none
// Long division of value * 2^STEPS by the precision, a few quotient bits per
// stage. The texture coordinate is tapped after TEX_STEPS fraction bits.
module sphv_div #(
   parameter int STEPS = sphv_pkg::SEG_STEPS
) (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [sphv_pkg::PW-1:0]          p_eff,
   input  logic [sphv_pkg::PW-1:0]          value,
   output logic [sphv_pkg::PHASE_W-1:0]     phase,
   output logic [sphv_pkg::OUT_W-1:0]       tex
);

   localparam int QW = sphv_pkg::PHASE_W + 1;

   typedef struct packed {
      logic [QW-1:0]                 q;
      logic [sphv_pkg::PW-1:0]       rem;
      logic [sphv_pkg::OUT_W-1:0]    tq;
      logic [sphv_pkg::PW-1:0]       trem;
   } div_stage_type;

   div_stage_type st_ff [sphv_pkg::DIV_STAGES];
   div_stage_type st_in [sphv_pkg::DIV_STAGES];
   div_stage_type init;
   logic [sphv_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [sphv_pkg::OUT_W-1:0]   tex_ff, tex_in;
   logic [sphv_pkg::PW-1:0]      half;
   div_stage_type                last_st;

   assign half = p_eff >> 1;

   always_comb begin
      init      = '0;
      init.q[0] = (value >= p_eff);
      init.rem  = (value >= p_eff) ? value - p_eff : value;
   end

   for (genvar s = 0; s < sphv_pkg::DIV_STAGES; s++) begin : g_st
      div_stage_type prev;
      if (s == 0) begin : g_first
         assign prev = init;
      end else begin : g_next
         assign prev = st_ff[s-1];
      end

      always_comb begin
         div_stage_type cur;
         logic [sphv_pkg::PW:0] r2;
         cur = prev;
         for (int k = 0; k < sphv_pkg::DIV_PER_STAGE; k++) begin
            if (s * sphv_pkg::DIV_PER_STAGE + k + 1 <= STEPS) begin
               r2 = {cur.rem, 1'b0};
               if (r2 >= {1'b0, p_eff}) begin
                  cur.rem = sphv_pkg::PW'(r2 - {1'b0, p_eff});
                  cur.q   = {cur.q[QW-2:0], 1'b1};
               end else begin
                  cur.rem = sphv_pkg::PW'(r2);
                  cur.q   = {cur.q[QW-2:0], 1'b0};
               end
               if (s * sphv_pkg::DIV_PER_STAGE + k + 1 == sphv_pkg::TEX_STEPS) begin
                  cur.tq   = cur.q[sphv_pkg::OUT_W-1:0];
                  cur.trem = cur.rem;
               end
            end
         end
         st_in[s] = cur;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // round half up: add one where the remainder reaches half the divisor
   assign last_st  = st_ff[sphv_pkg::DIV_STAGES-1];
   assign phase_in = last_st.q[sphv_pkg::PHASE_W-1:0] + sphv_pkg::PHASE_W'(
                     ({1'b0, last_st.rem} + {1'b0, half}) >= {1'b0, p_eff});
   assign tex_in   = last_st.tq + sphv_pkg::OUT_W'(
                     ({1'b0, last_st.trem} + {1'b0, half}) >= {1'b0, p_eff});

   always_ff @(posedge clock) begin
      if (adv) begin
         phase_ff <= phase_in;
         tex_ff   <= tex_in;
      end
   end

   assign phase = phase_ff;
   assign tex   = tex_ff;

endmodule
`default_nettype wire

[rtl/sphv_cordic.sv]
`default_nettype none
// Pipelined rotation: fold the phase into the right half plane, one
// micro-rotation per stage, then undo the fold.
module sphv_cordic (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic [sphv_pkg::PHASE_W-1:0]          phase,
   output logic signed [sphv_pkg::CORDIC_W-1:0]  cos_out,
   output logic signed [sphv_pkg::CORDIC_W-1:0]  sin_out
);

   typedef struct packed {
      logic signed [sphv_pkg::CORDIC_W-1:0]  x;
      logic signed [sphv_pkg::CORDIC_W-1:0]  y;
      logic signed [sphv_pkg::CORDIC_ZW-1:0] z;
      logic                                  flip;
   } cordic_stage_type;

   cordic_stage_type st_ff [sphv_pkg::CORDIC_STEPS+1];
   cordic_stage_type st_in [sphv_pkg::CORDIC_STEPS+1];
   logic signed [sphv_pkg::CORDIC_W-1:0]  cos_ff, cos_in;
   logic signed [sphv_pkg::CORDIC_W-1:0]  sin_ff, sin_in;
   logic signed [sphv_pkg::CORDIC_ZW-1:0] ang;

   assign ang = {phase[sphv_pkg::PHASE_W-1], phase};

   always_comb begin
      st_in[0].x    = sphv_pkg::CORDIC_GAIN;
      st_in[0].y    = '0;
      st_in[0].z    = ang;
      st_in[0].flip = 1'b0;
      if (ang > sphv_pkg::CORDIC_QUARTER) begin
         st_in[0].z    = ang - sphv_pkg::CORDIC_HALF;
         st_in[0].flip = 1'b1;
      end else if (ang < -sphv_pkg::CORDIC_QUARTER) begin
         st_in[0].z    = ang + sphv_pkg::CORDIC_HALF;
         st_in[0].flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar k = 0; k < sphv_pkg::CORDIC_STEPS; k++) begin : g_rot
      always_comb begin
         st_in[k+1].flip = st_ff[k].flip;
         if (st_ff[k].z >= 0) begin
            st_in[k+1].x = st_ff[k].x - (st_ff[k].y >>> k);
            st_in[k+1].y = st_ff[k].y + (st_ff[k].x >>> k);
            st_in[k+1].z = st_ff[k].z - sphv_pkg::CORDIC_ATAN[k];
         end else begin
            st_in[k+1].x = st_ff[k].x + (st_ff[k].y >>> k);
            st_in[k+1].y = st_ff[k].y - (st_ff[k].x >>> k);
            st_in[k+1].z = st_ff[k].z + sphv_pkg::CORDIC_ATAN[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k+1] <= st_in[k+1];
         end
      end
   end

   assign cos_in = st_ff[sphv_pkg::CORDIC_STEPS].flip ? -st_ff[sphv_pkg::CORDIC_STEPS].x
                                                      : st_ff[sphv_pkg::CORDIC_STEPS].x;
   assign sin_in = st_ff[sphv_pkg::CORDIC_STEPS].flip ? -st_ff[sphv_pkg::CORDIC_STEPS].y
                                                      : st_ff[sphv_pkg::CORDIC_STEPS].y;

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire

[rtl/sphv_back.sv]
`default_nettype none
module sphv_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sphv_pkg::PW-1:0]             p_eff,
   input  logic                                q_empty,
   input  sphv_pkg::cmd_type                   q_head,
   output logic                                q_pop,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [sphv_pkg::IDX_W-1:0]          rsp_vertex_index,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_x,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_y,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_pos_z,
   output logic [sphv_pkg::OUT_W-1:0]          rsp_tex_u,
   output logic [sphv_pkg::OUT_W-1:0]          rsp_tex_v,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_tangent_x,
   output logic signed [sphv_pkg::OUT_W-1:0]   rsp_tangent_z,
   output logic                                rsp_last,
   output logic                                rsp_bad_request
);

   localparam int OW = sphv_pkg::OUT_W;
   localparam int CW = sphv_pkg::CORDIC_W;
   localparam int PL = sphv_pkg::PIPE_LAT;
   localparam logic signed [OW-1:0] ONE = OW'(1 << sphv_pkg::FRAC_BITS);

   typedef struct packed {
      logic                      kind;
      logic                      bad;
      logic                      pole;
      logic                      north;
      logic [sphv_pkg::IDX_W-1:0] base;
      logic [OW-1:0]             tex_u;
      logic [OW-1:0]             tex_v;
   } side_type;

   function automatic logic signed [OW-1:0] round_sat(input logic signed [63:0] v,
                                                      input int sh);
      logic [63:0] m;
      logic signed [OW-1:0] r;
      m = v[63] ? $unsigned(-v) : $unsigned(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      if (m > (64'd1 << sphv_pkg::FRAC_BITS)) begin
         m = 64'd1 << sphv_pkg::FRAC_BITS;
      end
      r = OW'(m);
      return v[63] ? -r : r;
   endfunction

   side_type            sb_ff [PL];
   logic [PL-1:0]       sb_valid_ff;
   side_type            head_side;
   side_type            tex_side;
   side_type            tail;
   logic                tail_valid;
   logic                adv;

   logic [sphv_pkg::PHASE_W-1:0] seg_phase, ring_phase;
   logic [OW-1:0]                seg_tex, ring_tex;
   logic signed [CW-1:0]         cos_a, sin_a, cos_b, sin_b;

   logic signed [CW-1:0]  neg_ca_ff, sa_ff, abs_sb_ff, neg_cb_ff;
   logic signed [63:0]    prod_x_ff, prod_z_ff, prod_x_in, prod_z_in;
   logic signed [CW-1:0]  ny_ff;
   logic signed [OW-1:0]  px_ff, py_ff, pz_ff;

   logic [sphv_pkg::QSEQ_W-1:0] cnt_ff, cnt_in;
   logic quad_seq, out_free, load, consumed;
   logic [sphv_pkg::PW:0] p1;
   logic [sphv_pkg::PW:0] idx_off;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [sphv_pkg::IDX_W-1:0]   rsp_vertex_index_ff, rsp_vertex_index_in;
   logic signed [OW-1:0]         rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [OW-1:0]         rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [OW-1:0]         rsp_pos_z_ff, rsp_pos_z_in;
   logic [OW-1:0]                rsp_tex_u_ff, rsp_tex_u_in;
   logic [OW-1:0]                rsp_tex_v_ff, rsp_tex_v_in;
   logic signed [OW-1:0]         rsp_tangent_x_ff, rsp_tangent_x_in;
   logic signed [OW-1:0]         rsp_tangent_z_ff, rsp_tangent_z_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_bad_ff, rsp_bad_in;

   // pipeline control: the tail holds until its last result is loaded
   assign tail       = sb_ff[PL-1];
   assign tail_valid = sb_valid_ff[PL-1];
   assign quad_seq   = (tail.kind == sphv_pkg::KIND_INDEX) && !tail.bad;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load       = out_free && tail_valid;
   assign consumed   = load && (!quad_seq || cnt_ff == sphv_pkg::QUAD_LAST);
   assign adv        = !tail_valid || consumed;
   assign q_pop      = adv && !q_empty;

   always_comb begin
      head_side.kind  = q_head.kind;
      head_side.bad   = q_head.bad;
      head_side.pole  = q_head.pole;
      head_side.north = q_head.north;
      head_side.base  = q_head.base;
      head_side.tex_u = '0;
      head_side.tex_v = '0;
   end

   // pick up the texture coordinates as the divider delivers them
   always_comb begin
      tex_side       = sb_ff[sphv_pkg::TEX_STAGE-1];
      tex_side.tex_u = seg_tex;
      tex_side.tex_v = ring_tex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= '0;
      end else if (adv) begin
         sb_valid_ff <= {sb_valid_ff[PL-2:0], !q_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= head_side;
         for (int i = 1; i < PL; i++) begin
            if (i == sphv_pkg::TEX_STAGE) begin
               sb_ff[i] <= tex_side;
            end else begin
               sb_ff[i] <= sb_ff[i-1];
            end
         end
      end
   end

   sphv_div #(.STEPS(sphv_pkg::SEG_STEPS)) u_div_seg (
      .clock (clock),
      .adv   (adv),
      .p_eff (p_eff),
      .value (q_head.segment),
      .phase (seg_phase),
      .tex   (seg_tex)
   );

   sphv_div #(.STEPS(sphv_pkg::RING_STEPS)) u_div_ring (
      .clock (clock),
      .adv   (adv),
      .p_eff (p_eff),
      .value (q_head.ring),
      .phase (ring_phase),
      .tex   (ring_tex)
   );

   sphv_cordic u_cordic_seg (
      .clock   (clock),
      .adv     (adv),
      .phase   (seg_phase),
      .cos_out (cos_a),
      .sin_out (sin_a)
   );

   sphv_cordic u_cordic_ring (
      .clock   (clock),
      .adv     (adv),
      .phase   (ring_phase),
      .cos_out (cos_b),
      .sin_out (sin_b)
   );

   assign prod_x_in = neg_ca_ff * abs_sb_ff;
   assign prod_z_in = sa_ff * abs_sb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ca_ff <= -cos_a;
         sa_ff     <= sin_a;
         abs_sb_ff <= sin_b[CW-1] ? -sin_b : sin_b;
         neg_cb_ff <= -cos_b;
         prod_x_ff <= prod_x_in;
         prod_z_ff <= prod_z_in;
         ny_ff     <= neg_cb_ff;
         px_ff     <= round_sat(prod_x_ff, 60 - sphv_pkg::FRAC_BITS);
         pz_ff     <= round_sat(prod_z_ff, 60 - sphv_pkg::FRAC_BITS);
         py_ff     <= round_sat(64'(ny_ff), 30 - sphv_pkg::FRAC_BITS);
      end
   end

   assign p1 = {1'b0, p_eff} + 10'd1;

   always_comb begin
      case (cnt_ff)
         3'd1, 3'd3: idx_off = 10'd1;
         3'd2, 3'd5: idx_off = p1;
         3'd4:       idx_off = p1 + 10'd1;
         default:    idx_off = '0;
      endcase
   end

   always_comb begin
      rsp_kind_in         = tail.kind;
      rsp_bad_in          = tail.bad;
      rsp_last_in         = 1'b1;
      rsp_vertex_index_in = '0;
      rsp_pos_x_in        = '0;
      rsp_pos_y_in        = '0;
      rsp_pos_z_in        = '0;
      rsp_tex_u_in        = '0;
      rsp_tex_v_in        = '0;
      rsp_tangent_x_in    = '0;
      rsp_tangent_z_in    = '0;
      if (tail.bad) begin
         rsp_last_in = 1'b1;
      end else if (quad_seq) begin
         rsp_vertex_index_in = tail.base + sphv_pkg::IDX_W'(idx_off);
         rsp_last_in         = (cnt_ff == sphv_pkg::QUAD_LAST);
      end else begin
         rsp_tex_u_in = tail.tex_u;
         rsp_tex_v_in = tail.tex_v;
         if (tail.pole) begin
            rsp_pos_y_in     = tail.north ? ONE : -ONE;
            rsp_tangent_z_in = -ONE;
         end else begin
            rsp_pos_x_in     = px_ff;
            rsp_pos_y_in     = py_ff;
            rsp_pos_z_in     = pz_ff;
            rsp_tangent_x_in = pz_ff;
            rsp_tangent_z_in = -px_ff;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (load && quad_seq) begin
         cnt_in = (cnt_ff == sphv_pkg::QUAD_LAST) ? '0 : cnt_ff + 1'b1;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff         <= rsp_kind_in;
         rsp_vertex_index_ff <= rsp_vertex_index_in;
         rsp_pos_x_ff        <= rsp_pos_x_in;
         rsp_pos_y_ff        <= rsp_pos_y_in;
         rsp_pos_z_ff        <= rsp_pos_z_in;
         rsp_tex_u_ff        <= rsp_tex_u_in;
         rsp_tex_v_ff        <= rsp_tex_v_in;
         rsp_tangent_x_ff    <= rsp_tangent_x_in;
         rsp_tangent_z_ff    <= rsp_tangent_z_in;
         rsp_last_ff         <= rsp_last_in;
         rsp_bad_ff          <= rsp_bad_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_vertex_index = rsp_vertex_index_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_pos_z        = rsp_pos_z_ff;
   assign rsp_tex_u        = rsp_tex_u_ff;
   assign rsp_tex_v        = rsp_tex_v_ff;
   assign rsp_tangent_x    = rsp_tangent_x_ff;
   assign rsp_tangent_z    = rsp_tangent_z_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_bad_request  = rsp_bad_ff;

   a_run_only_quads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_kind_ff == sphv_pkg::KIND_INDEX && !rsp_bad_ff)
      else $error("non-final result outside a quad run");

   a_seq_on_quad: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> tail_valid && quad_seq)
      else $error("quad counter running without a quad at the tail");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && tail_valid |=> $stable(sb_valid_ff))
      else $error("pipeline moved while the output was stalled");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_last_ff && rsp_vertex_index_ff == '0
                                     && rsp_pos_y_ff == '0 && rsp_tangent_z_ff == '0)
      else $error("bad request result carries data");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                              kind;
      logic [sphv_pkg::IDX_W-1:0]        vidx;
      logic signed [sphv_pkg::OUT_W-1:0] px;
      logic signed [sphv_pkg::OUT_W-1:0] py;
      logic signed [sphv_pkg::OUT_W-1:0] pz;
      logic [sphv_pkg::OUT_W-1:0]        tu;
      logic [sphv_pkg::OUT_W-1:0]        tv;
      logic signed [sphv_pkg::OUT_W-1:0] tx;
      logic signed [sphv_pkg::OUT_W-1:0] tz;
      logic                              last;
      logic                              bad;
   } sph_result_type;

   typedef struct {
      logic           typ;
      int             ring;
      int             seg;
      bit             lit;
      sph_result_type res;
   } stim_row_type;

   localparam int     OW      = sphv_pkg::OUT_W;
   localparam longint ONE_Q14 = 64'sd1 << sphv_pkg::FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [sphv_pkg::PW-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = sphv_pkg::REQ_VERTEX;
   logic [sphv_pkg::PW-1:0] req_ring = '0;
   logic [sphv_pkg::PW-1:0] req_segment = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic [sphv_pkg::IDX_W-1:0] rsp_vertex_index;
   logic signed [OW-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [OW-1:0] rsp_tex_u, rsp_tex_v;
   logic signed [OW-1:0] rsp_tangent_x, rsp_tangent_z;
   logic rsp_last, rsp_bad_request;

   sph_result_type mesh_q[$];
   int unsigned err_cnt = 0;
   int unsigned req_taken = 0;
   logic [sphv_pkg::PW-1:0] prec_reg = sphv_pkg::PRECISION_RESET;
   bit idle_on = 1'b1;
   bit cur_lit = 1'b0;
   sph_result_type cur_res;
   int stall_left = 0;

   longint atan_tab[sphv_pkg::CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   uv_sphere_vertex_generator_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   function automatic void expect_add(input sph_result_type e);
      mesh_q.insert(mesh_q.size(), e);
   endfunction

   function automatic longint unsigned grid_size();
      if (prec_reg == 0) return 1;
      if (prec_reg > sphv_pkg::PRECISION_MAX) return sphv_pkg::MAX_PRECISION;
      return prec_reg;
   endfunction

   function automatic void rotate(input longint unsigned phase,
                                  output longint c, output longint s);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = longint'(phase & 64'hFFFF_FFFF);
      x = 652032874;
      y = 0;
      flip = 0;
      if (a >= 64'sd2147483648) a -= 64'sd4294967296;
      if (a > 64'sd1073741824) begin
         a -= 64'sd2147483648;
         flip = 1;
      end else if (a < -64'sd1073741824) begin
         a += 64'sd2147483648;
         flip = 1;
      end
      z = a;
      for (int k = 0; k < sphv_pkg::CORDIC_STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[k];
         end else begin
            x += dx; y -= dy; z += atan_tab[k];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic longint round_q14(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 << (sh - 1))) >>> sh;
      if (m > ONE_Q14) m = ONE_Q14;
      return (v < 0) ? -m : m;
   endfunction

   // queue the expected results of one request
   task automatic predict_mesh(input logic typ, input longint unsigned r,
                               input longint unsigned s);
      longint unsigned p, a, b;
      longint unsigned idx[6];
      longint cb, sb, ca, sa, px, py, pz;
      sph_result_type e;
      p = grid_size();
      e = '0;
      if ((typ == sphv_pkg::REQ_VERTEX && (r > p || s > p)) ||
          (typ == sphv_pkg::REQ_QUAD && (r >= p || s >= p))) begin
         e.kind = typ; e.last = 1; e.bad = 1;
         expect_add(e);
      end else if (typ == sphv_pkg::REQ_QUAD) begin
         a = r * (p + 1) + s;
         b = a + p + 1;
         idx = '{a, a + 1, b, a + 1, b + 1, b};
         for (int k = 0; k < 6; k++) begin
            e = '0;
            e.kind = sphv_pkg::KIND_INDEX;
            e.vidx = idx[k][sphv_pkg::IDX_W-1:0];
            e.last = (k == 5);
            expect_add(e);
         end
      end else begin
         if (r == 0 || r == p) begin
            px = 0; pz = 0;
            py = (r == 0) ? -ONE_Q14 : ONE_Q14;
            e.tz = OW'(-ONE_Q14);
         end else begin
            rotate(((r << 31) + p / 2) / p, cb, sb);
            rotate(((s << 32) + p / 2) / p, ca, sa);
            if (sb < 0) sb = -sb;
            py = round_q14(-cb, 30 - sphv_pkg::FRAC_BITS);
            px = round_q14(-ca * sb, 60 - sphv_pkg::FRAC_BITS);
            pz = round_q14(sa * sb, 60 - sphv_pkg::FRAC_BITS);
            e.tx = OW'(pz);
            e.tz = OW'(-px);
         end
         e.kind = sphv_pkg::KIND_VERTEX;
         e.px = OW'(px); e.py = OW'(py); e.pz = OW'(pz);
         e.tu = OW'(((s << 15) + p / 2) / p);
         e.tv = OW'(((r << 15) + p / 2) / p);
         e.last = 1;
         expect_add(e);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (cur_lit) expect_add(cur_res);
         else predict_mesh(req_type, req_ring, req_segment);
         req_taken++;
      end
   end

   always @(posedge clock) begin
      sph_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mesh_q.size() == 0) begin
            report("result with nothing pending");
         end else begin
            e = mesh_q.pop_front();
            if (rsp_kind !== e.kind) report($sformatf("kind %0d exp %0d", rsp_kind, e.kind));
            if (rsp_vertex_index !== e.vidx)
               report($sformatf("vertex_index %0d exp %0d", rsp_vertex_index, e.vidx));
            if (rsp_pos_x !== e.px) report($sformatf("pos_x %0d exp %0d", rsp_pos_x, e.px));
            if (rsp_pos_y !== e.py) report($sformatf("pos_y %0d exp %0d", rsp_pos_y, e.py));
            if (rsp_pos_z !== e.pz) report($sformatf("pos_z %0d exp %0d", rsp_pos_z, e.pz));
            if (rsp_tex_u !== e.tu) report($sformatf("tex_u %0d exp %0d", rsp_tex_u, e.tu));
            if (rsp_tex_v !== e.tv) report($sformatf("tex_v %0d exp %0d", rsp_tex_v, e.tv));
            if (rsp_tangent_x !== e.tx)
               report($sformatf("tangent_x %0d exp %0d", rsp_tangent_x, e.tx));
            if (rsp_tangent_z !== e.tz)
               report($sformatf("tangent_z %0d exp %0d", rsp_tangent_z, e.tz));
            if (rsp_last !== e.last) report($sformatf("last %0d exp %0d", rsp_last, e.last));
            if (rsp_bad_request !== e.bad)
               report($sformatf("bad_request %0d exp %0d", rsp_bad_request, e.bad));
         end
      end
   end

   // receiver back-pressure in bursts while idle_on is set
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_req(input logic typ, input int r, input int s,
                           input bit lit, input sph_result_type res);
      int unsigned taken0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      taken0 = req_taken;
      req_valid   <= 1'b1;
      req_type    <= typ;
      req_ring    <= r[sphv_pkg::PW-1:0];
      req_segment <= s[sphv_pkg::PW-1:0];
      cur_lit     <= lit;
      cur_res     <= res;
      do @(negedge clock); while (req_taken == taken0);
   endtask

   task automatic set_grid(input int v);
      req_valid <= 1'b0;
      @(negedge clock);
      while (mesh_q.size() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[sphv_pkg::PW-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      prec_reg = v[sphv_pkg::PW-1:0];
   endtask

   function automatic sph_result_type pole_res(input bit north, input int tu);
      sph_result_type e;
      e = '0;
      e.py = north ? OW'(ONE_Q14) : OW'(-ONE_Q14);
      e.tz = OW'(-ONE_Q14);
      e.tu = tu[OW-1:0];
      e.tv = north ? 16'd32768 : 16'd0;
      e.last = 1;
      return e;
   endfunction

   function automatic sph_result_type bad_res(input logic typ);
      sph_result_type e;
      e = '0;
      e.kind = typ; e.last = 1; e.bad = 1;
      return e;
   endfunction

   function automatic stim_row_type mk_row(input logic typ, input int r, input int s,
                                           input bit lit, input sph_result_type res);
      stim_row_type row;
      row.typ  = typ;
      row.ring = r;
      row.seg  = s;
      row.lit  = lit;
      row.res  = res;
      return row;
   endfunction

   initial begin
      stim_row_type rows[$];
      int p, r, s, n;
      logic typ;
      int prec_list[4];
      sph_result_type none;
      none = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset grid of 48
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 0, 0, 1, pole_res(0, 0)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 48, 17, 1, pole_res(1, 11605)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 49, 0, 1,
                                      bad_res(sphv_pkg::REQ_VERTEX)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 0, 49, 1,
                                      bad_res(sphv_pkg::REQ_VERTEX)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 511, 511, 1,
                                      bad_res(sphv_pkg::REQ_VERTEX)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_QUAD, 48, 0, 1,
                                      bad_res(sphv_pkg::REQ_QUAD)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_QUAD, 0, 48, 1,
                                      bad_res(sphv_pkg::REQ_QUAD)));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_QUAD, 0, 0, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_QUAD, 47, 47, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 24, 0, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 24, 12, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 1, 1, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 47, 48, 0, none));
      rows.insert(rows.size(), mk_row(sphv_pkg::REQ_VERTEX, 12, 36, 0, none));
      foreach (rows[i]) send_req(rows[i].typ, rows[i].ring, rows[i].seg, rows[i].lit,
                                 rows[i].res);

      // smallest and largest grids, plus the clamped register values
      set_grid(1);
      send_req(sphv_pkg::REQ_VERTEX, 1, 1, 0, none);
      send_req(sphv_pkg::REQ_VERTEX, 0, 1, 0, none);
      send_req(sphv_pkg::REQ_QUAD, 0, 0, 0, none);
      send_req(sphv_pkg::REQ_QUAD, 1, 0, 1, bad_res(sphv_pkg::REQ_QUAD));
      set_grid(256);
      send_req(sphv_pkg::REQ_QUAD, 255, 255, 0, none);
      send_req(sphv_pkg::REQ_VERTEX, 256, 256, 0, none);
      send_req(sphv_pkg::REQ_VERTEX, 128, 255, 0, none);
      set_grid(0);
      send_req(sphv_pkg::REQ_VERTEX, 1, 0, 0, none);
      send_req(sphv_pkg::REQ_QUAD, 0, 0, 0, none);
      set_grid(511);
      send_req(sphv_pkg::REQ_VERTEX, 256, 256, 0, none);
      send_req(sphv_pkg::REQ_VERTEX, 257, 3, 0, none);

      prec_list = '{48, $urandom_range(1, 511), 3, 256};
      foreach (prec_list[ph]) begin
         if (ph == 3) idle_on = 1'b0;
         set_grid(prec_list[ph]);
         p = int'(grid_size());
         for (n = 0; n < 60; n++) begin
            typ = ($urandom_range(0, 3) == 0) ? sphv_pkg::REQ_QUAD : sphv_pkg::REQ_VERTEX;
            if ($urandom_range(0, 9) == 0) begin
               r = $urandom_range(0, 511);
               s = $urandom_range(0, 511);
            end else if (typ == sphv_pkg::REQ_QUAD) begin
               r = $urandom_range(0, p - 1);
               s = $urandom_range(0, p - 1);
            end else begin
               r = $urandom_range(0, p);
               s = $urandom_range(0, p);
            end
            send_req(typ, r, s, 0, none);
         end
      end
      req_valid <= 1'b0;
      while (mesh_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
rtl/sphv_pkg.sv
rtl/sphv_front.sv
rtl/sphv_queue.sv
rtl/sphv_div.sv
rtl/sphv_cordic.sv
rtl/sphv_back.sv
rtl/uv_sphere_vertex_generator_core.sv
dv/tb_top.sv
